// File: design/sau_pkg.sv
// ----------------------------------------------------------------------------
// sau_pkg: shared types and constants for the stack arithmetic unit
// Operation and status codes, word width and the divider request/response.
// ----------------------------------------------------------------------------
package sau_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DEPTH_W  = 7;

  // operation codes carried in the input tuser
  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FEW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd3;

  // divider start request
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  // divider completion
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: design/sau_div.sv
// ----------------------------------------------------------------------------
// sau_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating
// toward zero. Quotient is valid while done is high.
// ----------------------------------------------------------------------------
module sau_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sau_pkg::div_req_t req_i,
  output sau_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W      = sau_pkg::DATA_W;
  localparam int unsigned STEP_W = $clog2(W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              neg_q, neg_d;
  logic [W-1:0]      rem_q, rem_d;
  logic [W-1:0]      quo_q, quo_d;
  logic [W-1:0]      dvs_q, dvs_d;
  logic [W:0]        diff;

  // trial subtract of the shifted remainder
  assign diff = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      neg_d  = req_i.dividend[W-1] ^ req_i.divisor[W-1];
      rem_d  = '0;
      quo_d  = req_i.dividend[W-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
      dvs_d  = req_i.divisor[W-1] ? (~req_i.divisor + 1'b1) : req_i.divisor;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// File: design/stack_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// stack_arithmetic_unit: operand stack with an integer ALU
// Signed 32-bit word stack in a synchronous memory; one operation per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: tuser carries the operation (push, pop, add, sub,
//   mul, div), tdata the operand for push. Output channel m_axis: one item
//   per input item with the result word (popped or computed value, else zero),
//   the status and the new depth. Arithmetic pops a (top), then b, and pushes a op b.
// Sequencing:
//   Push, no-op, full-push and too-few cases go straight to the output step;
//   pop reads the top first; add, sub, mul and divide by zero read a, then b,
//   then execute; div also waits for the divider. The single read port of the
//   stack memory serializes the two operand reads, and the one-bit-per-cycle
//   divider sets the divide time. One item is worked on at a time.
// Reset:
//   The stack is empty after reset; memory contents are not cleared, since
//   only entries below the count are read.
// Stall:
//   The result sits in an output register; a new item is accepted while it
//   waits, and the next result holds until the register frees up.
// ----------------------------------------------------------------------------
module stack_arithmetic_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] operand
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] kind
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] top_value, [38:32] depth, [39] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned W      = sau_pkg::DATA_W;
  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_POP  = 6'b000010,
    S_RDB  = 6'b000100,
    S_EXEC = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e                         state_q, state_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [sau_pkg::KIND_W-1:0]     kind_q, kind_d;
  logic [W-1:0]                   a_q, a_d;
  logic [W-1:0]                   res_top_q, res_top_d;
  logic [sau_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic                           out_valid_q, out_valid_d;
  logic [W-1:0]                   out_top_q;
  logic [sau_pkg::STATUS_W-1:0]   out_status_q;
  logic [sau_pkg::DEPTH_W-1:0]    out_depth_q;
  logic                           out_load;

  // stack memory
  logic [W-1:0]      mem [STACK_DEPTH];
  logic [W-1:0]      rd_data_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [W-1:0]      mem_wdata;

  logic [W-1:0]      prod;
  logic [W-1:0]      alu_res;
  logic              in_accept;

  sau_pkg::div_req_t div_req;
  sau_pkg::div_rsp_t div_rsp;

  sau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // a from register, b straight from the memory read port
  assign prod = a_q * rd_data_q;
  always_comb begin
    case (kind_q)
      sau_pkg::KIND_ADD: alu_res = a_q + rd_data_q;
      sau_pkg::KIND_SUB: alu_res = a_q - rd_data_q;
      default:           alu_res = prod;
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    kind_d       = kind_q;
    a_d          = a_q;
    res_top_d    = res_top_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = ADDR_W'(cnt_q - 1'b1);
    mem_wdata    = alu_res;
    mem_raddr    = ADDR_W'(cnt_q - 1'b1);
    div_req      = '0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          kind_d       = s_axis_tuser_i;
          res_top_d    = '0;
          res_status_d = sau_pkg::ST_OK;
          state_d      = S_DONE;
          case (s_axis_tuser_i) inside
            sau_pkg::KIND_PUSH: begin
              if (cnt_q < CNT_FULL) begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(cnt_q);
                mem_wdata = s_axis_tdata_i;
                cnt_d     = cnt_q + 1'b1;
              end else begin
                res_status_d = sau_pkg::ST_FULL;
              end
            end
            sau_pkg::KIND_POP: begin
              if (cnt_q != '0) begin
                state_d = S_POP;
              end else begin
                res_status_d = sau_pkg::ST_FEW;
              end
            end
            sau_pkg::KIND_ADD, sau_pkg::KIND_SUB,
            sau_pkg::KIND_MUL, sau_pkg::KIND_DIV: begin
              if (cnt_q >= CNT_TWO) begin
                state_d = S_RDB;
              end else begin
                res_status_d = sau_pkg::ST_FEW;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        res_top_d = rd_data_q;
        cnt_d     = cnt_q - 1'b1;
        state_d   = S_DONE;
      end
      S_RDB: begin
        a_d       = rd_data_q;
        mem_raddr = ADDR_W'(cnt_q - CNT_TWO);
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        mem_waddr = ADDR_W'(cnt_q - CNT_TWO);
        if (kind_q == sau_pkg::KIND_DIV) begin
          if (rd_data_q == '0) begin
            res_status_d = sau_pkg::ST_DIVZ;
            state_d      = S_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = a_q;
            div_req.divisor  = rd_data_q;
            state_d          = S_DIV;
          end
        end else begin
          mem_we    = 1'b1;
          cnt_d     = cnt_q - 1'b1;
          res_top_d = alu_res;
          state_d   = S_DONE;
        end
      end
      S_DIV: begin
        mem_waddr = ADDR_W'(cnt_q - CNT_TWO);
        mem_wdata = div_rsp.quotient;
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          cnt_d     = cnt_q - 1'b1;
          res_top_d = div_rsp.quotient;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    a_q          <= a_d;
    res_top_q    <= res_top_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_top_q    <= res_top_q;
      out_status_q <= res_status_q;
      out_depth_q  <= sau_pkg::DEPTH_W'(cnt_q);
    end
  end

  // stack memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_depth_q, out_top_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule
